// ----- src/tsch_pkg.sv -----
// Shared types and codes for the task scheduler.
// Used by tsch_mem, tsch_pick and cpu_task_scheduler_fifo_srtf_rr.
package tsch_pkg;

    localparam int TASK_SLOTS_DEF = 32;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_SRTF = 2'd1;
    localparam logic [1:0] POL_RR   = 2'd2;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // one task entry of the statistics memory
    typedef struct packed {
        logic [7:0]  rem;
        logic [15:0] comp;
        logic [15:0] wt;
    } t_stat;

    typedef struct packed {
        logic rd;
        logic st_we;
        logic ar_we;
        logic clr;
    } t_mem_ctl;

    typedef struct packed {
        logic clr;
        logic step;
    } t_pick_ctl;

endpackage

// ----- src/tsch_mem.sv -----
// Task memories: statistics entries with valid bits, and arrival times.
// Depends on tsch_pkg.
module tsch_mem import tsch_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mem_ctl                      i_ctl,
    input  logic [$clog2(TASK_SLOTS)-1:0] i_rd_addr,
    input  logic [$clog2(TASK_SLOTS)-1:0] i_wr_addr,
    input  t_stat                         i_wr_stat,
    input  logic [11:0]                   i_wr_arr,
    output t_stat                         o_rd_stat,
    output logic [11:0]                   o_rd_arr
);

    t_stat             r_stat_mem [TASK_SLOTS];
    logic [11:0]       r_arr_mem  [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] r_vld;
    t_stat             r_rd_stat;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.st_we) begin
            r_stat_mem[i_wr_addr] <= i_wr_stat;
        end
        if (i_ctl.ar_we) begin
            r_arr_mem[i_wr_addr] <= i_wr_arr;
        end
        if (i_ctl.rd) begin
            r_rd_stat <= r_stat_mem[i_rd_addr];
            o_rd_arr  <= r_arr_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_vld <= '0;
            end else if (i_ctl.st_we) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // an entry never written since reset or clear reads as zero
    assign o_rd_stat = r_rd_vld ? r_rd_stat : '0;

endmodule

// ----- src/tsch_pick.sv -----
// Running task selection over one scan of the table, plus ready count.
// Depends on tsch_pkg.
module tsch_pick import tsch_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_pick_ctl                       i_ctl,
    input  logic [$clog2(TASK_SLOTS)-1:0]   i_slot,
    input  t_stat                           i_stat,
    input  logic [11:0]                     i_arr,
    input  logic [15:0]                     i_tick,
    input  logic [1:0]                      i_policy,
    input  logic [$clog2(TASK_SLOTS)-1:0]   i_last_run,
    output logic                            o_ready,
    output logic                            o_have,
    output logic [$clog2(TASK_SLOTS)-1:0]   o_pick,
    output t_stat                           o_pick_stat,
    output logic [$clog2(TASK_SLOTS+1)-1:0] o_rdy_cnt
);

    localparam int LW = $clog2(TASK_SLOTS + 1);

    logic          r_nz;
    logic          r_after;
    logic          w_after;
    logic          w_take;

    assign o_ready = (i_stat.rem != 8'd0) && ({4'd0, i_arr} <= i_tick);
    assign w_after = i_slot > i_last_run;

    always_comb begin
        case (i_policy)
            POL_SRTF: w_take = o_ready && (!o_have || i_stat.rem < o_pick_stat.rem);
            // prefer the first ready slot after the last one run, else wrap
            POL_RR:   w_take = o_ready && (!o_have || (w_after && !r_after));
            default:  w_take = o_ready && !r_nz;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_have    <= 1'b0;
            r_nz      <= 1'b0;
            r_after   <= 1'b0;
            o_rdy_cnt <= '0;
        end else if (i_ctl.clr) begin
            o_have    <= 1'b0;
            r_nz      <= 1'b0;
            r_after   <= 1'b0;
            o_rdy_cnt <= '0;
        end else if (i_ctl.step) begin
            if (i_stat.rem != 8'd0) begin
                r_nz <= 1'b1;
            end
            if (o_ready) begin
                o_rdy_cnt <= o_rdy_cnt + LW'(1);
            end
            if (w_take) begin
                o_have  <= 1'b1;
                r_after <= w_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && w_take) begin
            o_pick      <= i_slot;
            o_pick_stat <= i_stat;
        end
    end

endmodule

// ----- src/cpu_task_scheduler_fifo_srtf_rr.sv -----
// Top level of the task scheduler: command port, APB policy register, sequencer.
// Depends on tsch_pkg, tsch_mem and tsch_pick.
//
// channel   direction  handshake                    payload
// command   in         start high, busy low         i_operation, i_task_index,
//                                                   i_arrival_time, i_service_time
// result    out        o_valid, one cycle, no stall  o_idle .. o_wait_ticks
// config    in         APB psel/penable/pwrite       paddr, pwdata (policy)
//
// A tick scans the statistics memory, one slot read per cycle through its single
// read port, and then makes one fix-up write of the chosen task.
// Reset (synchronous, active low) empties all slots through the valid bits at once.
// The result beat is shown for one cycle with busy already low; the receiver
// cannot stall it.
module cpu_task_scheduler_fifo_srtf_rr import tsch_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [4:0]  i_task_index,
    input  logic [11:0] i_arrival_time,
    input  logic [7:0]  i_service_time,
    output logic        o_valid,
    output logic        o_idle,
    output logic [4:0]  o_running_task,
    output logic [7:0]  o_running_remaining,
    output logic [5:0]  o_ready_waiting,
    output logic        o_task_done,
    output logic        o_all_done,
    output logic [15:0] o_tick_time,
    output logic [15:0] o_finish_tick,
    output logic [15:0] o_turnaround_time,
    output logic [15:0] o_wait_ticks,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = $clog2(TASK_SLOTS);
    localparam int LW = $clog2(TASK_SLOTS + 1);

    typedef enum logic [2:0] {S_IDLE, S_REQ, S_RD, S_SCAN, S_FIX} t_state;

    t_state          r_state;
    logic [1:0]      r_policy;
    logic [1:0]      r_op;
    logic [4:0]      r_idx;
    logic [11:0]     r_arr;
    logic [7:0]      r_svc;
    logic [15:0]     r_tick;
    logic [SW-1:0]   r_last_run;
    logic [LW-1:0]   r_live;
    logic [LW-1:0]   r_cnt;
    logic            r_dv;
    logic [SW-1:0]   r_dslot;

    logic            w_accept;
    logic            w_in_range;
    logic [SW-1:0]   w_idx_addr;
    t_mem_ctl        w_mem_ctl;
    logic [SW-1:0]   w_rd_addr;
    logic [SW-1:0]   w_wr_addr;
    t_stat           w_wr_stat;
    t_stat           w_rd_stat;
    logic [11:0]     w_rd_arr;
    t_pick_ctl       w_pick_ctl;
    logic            w_ready;
    logic            w_have;
    logic [SW-1:0]   w_pick;
    t_stat           w_pick_stat;
    logic [LW-1:0]   w_rdy_cnt;
    logic [7:0]      w_rem_dec;
    logic [15:0]     w_tick_inc;
    logic [LW-1:0]   n_live_load;
    logic [LW-1:0]   n_live_fix;
    logic [LW-1:0]   w_waiting;
    logic [15:0]     w_arr16;
    logic            w_scan_last;

    assign busy     = (r_state != S_IDLE);
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : {30'd0, r_policy};
    assign w_accept = start && !busy;

    assign w_in_range  = (int'(r_idx) < TASK_SLOTS);
    assign w_idx_addr  = SW'(r_idx);
    assign w_rem_dec   = w_pick_stat.rem - 8'd1;
    assign w_tick_inc  = (r_tick == CNT_MAX) ? CNT_MAX : r_tick + 16'd1;
    assign w_arr16     = {4'd0, w_rd_arr};
    assign w_scan_last = r_dv && (r_dslot == SW'(TASK_SLOTS - 1));
    assign w_waiting   = w_rdy_cnt - LW'(w_have);

    // live slot count after a load: add the new entry, drop the one it replaces
    assign n_live_load = r_live + LW'(r_svc != 8'd0) - LW'(w_rd_stat.rem != 8'd0);
    assign n_live_fix  = r_live - LW'(w_have && w_rem_dec == 8'd0);

    // memory access per state; the scan writes slot k while reading slot k+1,
    // and the fix-up write comes after the scan, so no two accesses collide
    always_comb begin
        w_mem_ctl = '0;
        w_rd_addr = w_idx_addr;
        w_wr_addr = w_idx_addr;
        w_wr_stat = '0;
        case (r_state)
            S_IDLE: begin
                w_mem_ctl.clr = w_accept && (i_operation == OP_CLEAR);
            end
            S_REQ: begin
                w_mem_ctl.rd = 1'b1;
            end
            S_RD: begin
                if (r_op == OP_LOAD && w_in_range) begin
                    w_mem_ctl.st_we = 1'b1;
                    w_mem_ctl.ar_we = 1'b1;
                    w_wr_stat.rem   = r_svc;
                end
            end
            S_SCAN: begin
                w_rd_addr    = r_cnt[SW-1:0];
                w_mem_ctl.rd = (int'(r_cnt) < TASK_SLOTS);
                w_wr_addr    = r_dslot;
                // count a wait for every ready slot; the chosen one is restored later
                w_wr_stat    = w_rd_stat;
                w_wr_stat.wt = (w_rd_stat.wt == CNT_MAX) ? CNT_MAX : w_rd_stat.wt + 16'd1;
                w_mem_ctl.st_we = r_dv && w_ready;
            end
            S_FIX: begin
                w_wr_addr       = w_pick;
                w_wr_stat       = w_pick_stat;
                w_wr_stat.rem   = w_rem_dec;
                if (w_rem_dec == 8'd0) begin
                    w_wr_stat.comp = w_tick_inc;
                end
                w_mem_ctl.st_we = w_have;
            end
            default: begin
                w_mem_ctl = '0;
            end
        endcase
    end

    assign w_pick_ctl.clr  = w_accept && (i_operation == OP_TICK);
    assign w_pick_ctl.step = (r_state == S_SCAN) && r_dv;

    tsch_mem #(.TASK_SLOTS(TASK_SLOTS)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_mem_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_stat (w_wr_stat),
        .i_wr_arr  (r_arr),
        .o_rd_stat (w_rd_stat),
        .o_rd_arr  (w_rd_arr)
    );

    tsch_pick #(.TASK_SLOTS(TASK_SLOTS)) u_pick (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_pick_ctl),
        .i_slot      (r_dslot),
        .i_stat      (w_rd_stat),
        .i_arr       (w_rd_arr),
        .i_tick      (r_tick),
        .i_policy    (r_policy),
        .i_last_run  (r_last_run),
        .o_ready     (w_ready),
        .o_have      (w_have),
        .o_pick      (w_pick),
        .o_pick_stat (w_pick_stat),
        .o_rdy_cnt   (w_rdy_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_policy   <= POL_FIFO;
            r_tick     <= 16'd0;
            r_last_run <= SW'(TASK_SLOTS - 1);
            r_live     <= '0;
            r_cnt      <= '0;
            r_dv       <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (psel && penable && pwrite && pready && !paddr[2]) begin
                r_policy <= pwdata[1:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op  <= i_operation;
                        r_idx <= i_task_index;
                        r_arr <= i_arrival_time;
                        r_svc <= i_service_time;
                        // zero every result field but all_done; each operation fills its own
                        o_idle              <= 1'b0;
                        o_running_task      <= 5'd0;
                        o_running_remaining <= 8'd0;
                        o_ready_waiting     <= 6'd0;
                        o_task_done         <= 1'b0;
                        o_tick_time         <= 16'd0;
                        o_finish_tick       <= 16'd0;
                        o_turnaround_time   <= 16'd0;
                        o_wait_ticks        <= 16'd0;
                        case (i_operation)
                            OP_CLEAR: begin
                                r_tick     <= 16'd0;
                                r_last_run <= SW'(TASK_SLOTS - 1);
                                r_live     <= '0;
                                o_all_done <= 1'b1;
                                o_valid    <= 1'b1;
                            end
                            OP_TICK: begin
                                r_cnt   <= '0;
                                r_dv    <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_REQ;
                            end
                        endcase
                    end
                end
                S_REQ: begin
                    r_state <= S_RD;
                end
                S_RD: begin
                    o_valid    <= 1'b1;
                    o_all_done <= (r_live == '0);
                    r_state    <= S_IDLE;
                    if (w_in_range) begin
                        if (r_op == OP_LOAD) begin
                            r_live     <= n_live_load;
                            o_all_done <= (n_live_load == '0);
                        end else begin
                            o_finish_tick <= w_rd_stat.comp;
                            o_wait_ticks  <= w_rd_stat.wt;
                            if (w_rd_stat.comp != 16'd0 && w_rd_stat.comp >= w_arr16) begin
                                o_turnaround_time <= w_rd_stat.comp - w_arr16;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    // one slot read per cycle; data for slot k arrives in the next cycle
                    r_dv    <= (int'(r_cnt) < TASK_SLOTS);
                    r_dslot <= r_cnt[SW-1:0];
                    if (int'(r_cnt) < TASK_SLOTS) begin
                        r_cnt <= r_cnt + LW'(1);
                    end
                    if (w_scan_last) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    o_valid         <= 1'b1;
                    o_tick_time     <= r_tick;
                    o_ready_waiting <= (int'(w_waiting) > 63) ? 6'd63 : 6'(w_waiting);
                    o_idle          <= !w_have;
                    if (w_have) begin
                        o_running_task      <= 5'(w_pick);
                        o_running_remaining <= w_pick_stat.rem;
                        o_task_done         <= (w_rem_dec == 8'd0);
                        r_last_run          <= w_pick;
                    end
                    r_live     <= n_live_fix;
                    o_all_done <= (n_live_fix == '0);
                    r_tick     <= w_tick_inc;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // any operation but clear keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation != OP_CLEAR) |=> busy)
        else $error("busy not raised after accept");

    // a result beat only ever appears once the sequencer is back at rest
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    // an idle tick reports no finished task
    a_idle_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_idle) |-> (!o_task_done && o_running_remaining == 8'd0))
        else $error("idle tick with running task data");

    // the live slot count never exceeds the table size
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_live) <= TASK_SLOTS)
        else $error("live slot count overflow");

endmodule

// ----- tb/sv/cpu_task_scheduler_fifo_srtf_rr_test.sv -----
// Self-checking testbench for the FIFO / SRTF / round-robin task scheduler.
// Depends on tsch_pkg and cpu_task_scheduler_fifo_srtf_rr.
`timescale 1ns / 1ps

module cpu_task_scheduler_fifo_srtf_rr_test import tsch_pkg::*;;

    localparam int SLOTS = TASK_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 1500000;

    // one command beat and one result beat
    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  idx;
        logic [11:0] arr;
        logic [7:0]  svc;
    } t_cmd;

    typedef struct packed {
        logic        idle;
        logic [4:0]  run_task;
        logic [7:0]  run_rem;
        logic [5:0]  waiting;
        logic        done;
        logic        all_done;
        logic [15:0] tick_t;
        logic [15:0] comp_t;
        logic [15:0] turn_t;
        logic [15:0] wait_t;
    } t_res;

    // directed row: command plus optional typed-in expectation
    typedef struct {
        t_cmd c;
        bit   has_exp;
        t_res e;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_operation = '0;
    logic [4:0]  i_task_index = '0;
    logic [11:0] i_arrival_time = '0;
    logic [7:0]  i_service_time = '0;
    logic        o_valid, o_idle, o_task_done, o_all_done;
    logic [4:0]  o_running_task;
    logic [7:0]  o_running_remaining;
    logic [5:0]  o_ready_waiting;
    logic [15:0] o_tick_time, o_finish_tick, o_turnaround_time, o_wait_ticks;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cpu_task_scheduler_fifo_srtf_rr dut (.*);

    always #1 i_clk = ~i_clk;

    // scheduler shadow state
    logic [11:0] sh_arr [SLOTS];
    logic [7:0]  sh_rem [SLOTS];
    logic [15:0] sh_comp [SLOTS];
    logic [15:0] sh_wait [SLOTS];
    bit          sh_arr_set [SLOTS];
    logic [15:0] sh_clock;
    logic [4:0]  sh_last;
    logic [5:0]  sh_loaded;
    logic [1:0]  sh_policy;

    t_res  pending_results [$];
    int    fail_count = 0;
    int    result_count = 0;
    int    cmd_count = 0;
    int    tick_count = 0;
    int    cycle_count = 0;

    function automatic bit slot_ready(int s);
        return sh_rem[s] != 0 && sh_arr[s] <= sh_clock;
    endfunction

    function automatic bit table_empty();
        for (int s = 0; s < SLOTS; s++)
            if (sh_rem[s] != 0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void clear_shadow();
        for (int s = 0; s < SLOTS; s++) begin
            sh_rem[s] = '0;
            sh_comp[s] = '0;
            sh_wait[s] = '0;
        end
        sh_clock = '0;
        sh_last = 5'(SLOTS - 1);
        sh_loaded = '0;
    endfunction

    // pick a slot per policy; SLOTS means idle
    function automatic int pick_slot();
        int p;
        p = SLOTS;
        if (sh_policy == POL_SRTF) begin
            for (int s = 0; s < SLOTS; s++)
                if (slot_ready(s) && (p == SLOTS || sh_rem[s] < sh_rem[p])) p = s;
        end else if (sh_policy == POL_RR) begin
            for (int k = 1; k <= SLOTS; k++) begin
                int s;
                s = (sh_last + k) % SLOTS;
                if (slot_ready(s)) begin
                    p = s;
                    break;
                end
            end
        end else begin
            for (int s = 0; s < SLOTS; s++)
                if (sh_rem[s] != 0) begin
                    p = s;
                    break;
                end
            if (p != SLOTS && !slot_ready(p)) p = SLOTS;
        end
        return p;
    endfunction

    // advance the shadow by one command and return the result it yields
    function automatic t_res schedule_step(t_cmd c);
        t_res r;
        int   p;
        r = '{default: '0};
        case (c.op)
            OP_LOAD: begin
                sh_arr[c.idx] = c.arr;
                sh_arr_set[c.idx] = 1'b1;
                sh_rem[c.idx] = c.svc;
                sh_comp[c.idx] = '0;
                sh_wait[c.idx] = '0;
                if (sh_loaded < 63) sh_loaded++;
            end
            OP_TICK: begin
                p = pick_slot();
                for (int s = 0; s < SLOTS; s++)
                    if (s != p && slot_ready(s)) begin
                        if (r.waiting < 63) r.waiting++;
                        if (sh_wait[s] != CNT_MAX) sh_wait[s]++;
                    end
                r.tick_t = sh_clock;
                if (p == SLOTS) begin
                    r.idle = 1'b1;
                end else begin
                    r.run_task = 5'(p);
                    r.run_rem = sh_rem[p];
                    sh_rem[p]--;
                    if (sh_rem[p] == 0) begin
                        sh_comp[p] = (sh_clock != CNT_MAX) ? sh_clock + 16'd1 : CNT_MAX;
                        r.done = 1'b1;
                    end
                    sh_last = 5'(p);
                end
                if (sh_clock != CNT_MAX) sh_clock++;
            end
            OP_READ: begin
                r.comp_t = sh_comp[c.idx];
                r.turn_t = (r.comp_t != 0 && r.comp_t >= sh_arr[c.idx]) ?
                           r.comp_t - sh_arr[c.idx] : '0;
                r.wait_t = sh_wait[c.idx];
            end
            default: clear_shadow();
        endcase
        r.all_done = table_empty();
        return r;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(negedge i_clk);
    endtask

    // APB write of the policy register; only called while idle
    task automatic write_policy(logic [1:0] pol);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {30'd0, pol};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sh_policy = pol;
    endtask

    // hold start until the beat is taken, then predict; with no gap start
    // stays high so the next command follows at once
    task automatic send_cmd(t_cmd c, bit has_exp, t_res e, int gap);
        t_res r;
        i_operation <= c.op;
        i_task_index <= c.idx;
        i_arrival_time <= c.arr;
        i_service_time <= c.svc;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        r = schedule_step(c);
        cmd_count++;
        if (c.op == OP_TICK) tick_count++;
        if (has_exp && r != e) begin
            $error("directed row prediction disagrees with typed expectation");
            fail_count++;
        end
        pending_results.push_back(r);
        @(negedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            idle_cycles(gap);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        idle_cycles(SLOTS + 8);
    endtask

    // compare every result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_res e;
            result_count++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_idle !== e.idle) begin
                    $error("idle exp %0d got %0d", e.idle, o_idle); fail_count++;
                end
                if (o_running_task !== e.run_task) begin
                    $error("running_task exp %0d got %0d", e.run_task, o_running_task);
                    fail_count++;
                end
                if (o_running_remaining !== e.run_rem) begin
                    $error("running_remaining exp %0d got %0d", e.run_rem,
                           o_running_remaining);
                    fail_count++;
                end
                if (o_ready_waiting !== e.waiting) begin
                    $error("ready_waiting exp %0d got %0d", e.waiting, o_ready_waiting);
                    fail_count++;
                end
                if (o_task_done !== e.done) begin
                    $error("task_done exp %0d got %0d", e.done, o_task_done); fail_count++;
                end
                if (o_all_done !== e.all_done) begin
                    $error("all_done exp %0d got %0d", e.all_done, o_all_done);
                    fail_count++;
                end
                if (o_tick_time !== e.tick_t) begin
                    $error("tick_time exp %0d got %0d", e.tick_t, o_tick_time);
                    fail_count++;
                end
                if (o_finish_tick !== e.comp_t) begin
                    $error("finish_tick exp %0d got %0d", e.comp_t, o_finish_tick);
                    fail_count++;
                end
                if (o_turnaround_time !== e.turn_t) begin
                    $error("turnaround_time exp %0d got %0d", e.turn_t, o_turnaround_time);
                    fail_count++;
                end
                if (o_wait_ticks !== e.wait_t) begin
                    $error("wait_ticks exp %0d got %0d", e.wait_t, o_wait_ticks);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("cpu_task_scheduler_fifo_srtf_rr verification failed");
            $finish;
        end
    end

    function automatic t_cmd mk(logic [1:0] op, int idx, int arr, int svc);
        t_cmd c;
        c.op = op;
        c.idx = 5'(idx);
        c.arr = 12'(arr);
        c.svc = 8'(svc);
        return c;
    endfunction

    // random command: pick a readable slot so no unwritten arrival is read
    function automatic t_cmd rand_cmd(int mode);
        t_cmd c;
        int   w;
        int   k;
        w = $urandom_range(0, 99);
        c = mk(OP_TICK, $urandom_range(0, 31), $urandom_range(0, 4095),
               $urandom_range(0, 255));
        if (w < 18) begin
            c.op = OP_LOAD;
            // mostly small arrivals and service so tasks actually run and finish
            if (mode != 0) begin
                c.arr = 12'(sh_clock + $urandom_range(0, 40));
                c.svc = 8'($urandom_range(1, 12));
            end
        end else if (w < 30) begin
            c.op = OP_READ;
            k = 0;
            while (!sh_arr_set[c.idx] && k < 64) begin
                c.idx = 5'($urandom_range(0, 31));
                k++;
            end
            if (!sh_arr_set[c.idx]) c.op = OP_TICK;
        end else if (w < 31) begin
            c.op = OP_CLEAR;
        end
        return c;
    endfunction

    t_row rows [$];
    t_res none;

    initial begin
        t_cmd c;
        t_res e;
        none = '{default: '0};
        for (int s = 0; s < SLOTS; s++) begin
            sh_arr[s] = '0;
            sh_arr_set[s] = 1'b0;
        end
        sh_policy = POL_FIFO;
        clear_shadow();

        // directed table; expectations typed only where obvious
        e = none; e.all_done = 1'b1;
        rows.push_back('{mk(OP_TICK, 0, 0, 0), 1'b1, '{1, 0, 0, 0, 0, 1, 0, 0, 0, 0}});
        rows.push_back('{mk(OP_LOAD, 0, 0, 1), 1'b1, '{default: '0}});
        rows.push_back('{mk(OP_LOAD, 31, 4095, 255), 1'b0, none});
        rows.push_back('{mk(OP_LOAD, 5, 2, 0), 1'b0, none});     // zero service
        rows.push_back('{mk(OP_LOAD, 3, 1, 3), 1'b0, none});
        rows.push_back('{mk(OP_LOAD, 4, 1, 2), 1'b0, none});
        rows.push_back('{mk(OP_TICK, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(OP_TICK, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(OP_READ, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(OP_READ, 5, 0, 0), 1'b0, none});
        rows.push_back('{mk(OP_LOAD, 3, 0, 4), 1'b0, none});     // reload
        rows.push_back('{mk(OP_TICK, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(OP_TICK, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(OP_READ, 4, 0, 0), 1'b0, none});
        rows.push_back('{mk(OP_READ, 31, 0, 0), 1'b0, none});
        rows.push_back('{mk(OP_CLEAR, 0, 0, 0), 1'b1, e});
        rows.push_back('{mk(OP_READ, 31, 0, 0), 1'b1, e});

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // walk the table under each policy, policy three included
        for (int pol = 0; pol < 4; pol++) begin
            write_policy(2'(pol));
            foreach (rows[i]) begin
                send_cmd(rows[i].c, rows[i].has_exp && pol == 0 && i < 2, rows[i].e,
                         $urandom_range(0, 2) == 0 ? $urandom_range(0, 15) : 0);
            end
            drain();
        end

        // random phases: well-formed bursts with occasional wild loads
        for (int ph = 0; ph < 12; ph++) begin
            write_policy(2'(ph % 4 == 3 ? $urandom_range(0, 3) : ph % 3));
            for (int n = 0; n < 90; n++) begin
                c = rand_cmd($urandom_range(0, 9) != 0);
                send_cmd(c, 1'b0, none, ph % 2 == 0 ? $urandom_range(0, 15) : 0);
            end
            drain();
        end

        $display("covered %0d commands, %0d ticks, %0d results over all policies",
                 cmd_count, tick_count, result_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("cpu_task_scheduler_fifo_srtf_rr verification clean");
        else
            $display("cpu_task_scheduler_fifo_srtf_rr verification failed");
        $finish;
    end
endmodule
